### rtl/patk_pkg.sv
`default_nettype none

package patk_pkg;

   localparam int INDEX_BITS     = 16;
   localparam int CORDIC_STEPS   = 28;
   localparam int STEP_BITS      = $clog2(CORDIC_STEPS);
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);
   localparam int CSR_INDEX_BITS = 2;
   localparam int XY_W           = 48;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_DOMAIN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRETCH    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_ADJ = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLE_TOL   = 2'd3;

   localparam logic [31:0] ONE_Q24      = 32'h0100_0000;
   localparam logic [63:0] INVPI_Q62    = 64'h145F_306D_C9C8_82A5;
   localparam logic [63:0] QUARTER_Q62  = 64'h1000_0000_0000_0000;
   localparam logic [63:0] SUM_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [INDEX_BITS-1:0] target_index;
      logic signed [31:0]    tgt_pos;
      logic signed [31:0]    src_pos;
      logic signed [31:0]    src_charge;
      logic signed [31:0]    src_weight;
      logic                  last_source;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] result_target;
      logic signed [63:0]    potential_increment;
   } rsp_type;

   typedef struct packed {
      logic [31:0] inv_domain_length;
      logic [31:0] stretch;
      logic [31:0] weight_adjust;
      logic [7:0]  pole_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic                  skip;
      logic                  last;
      logic signed [23:0]    phase;
      logic [24:0]           frac;
      logic signed [39:0]    qw;
   } pair_type;

   typedef logic signed [63:0] angle_arr_type [CORDIC_STEPS];

   function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
      logic [63:0] q;
      case (k)
         0:  q = v / 1;
         1:  q = v / 3;
         2:  q = v / 5;
         3:  q = v / 7;
         4:  q = v / 9;
         5:  q = v / 11;
         6:  q = v / 13;
         7:  q = v / 15;
         8:  q = v / 17;
         9:  q = v / 19;
         10: q = v / 21;
         11: q = v / 23;
         12: q = v / 25;
         13: q = v / 27;
         14: q = v / 29;
         15: q = v / 31;
         16: q = v / 33;
         17: q = v / 35;
         18: q = v / 37;
         19: q = v / 39;
         20: q = v / 41;
         21: q = v / 43;
         22: q = v / 45;
         23: q = v / 47;
         24: q = v / 49;
         25: q = v / 51;
         26: q = v / 53;
         27: q = v / 55;
         28: q = v / 57;
         29: q = v / 59;
         30: q = v / 61;
         31: q = v / 63;
         default: q = v;
      endcase
      return q;
   endfunction

   // Arctangent of 2^-i in half-turns, Q.62, from the alternating series.
   function automatic logic signed [63:0] half_turn_angle(input int i);
      logic signed [63:0] sum;
      logic signed [63:0] t;
      int sh;
      int k;
      sum = '0;
      sh  = i;
      if (i == 0) begin
         sum = QUARTER_Q62;
      end else begin
         for (k = 0; k < 32; k++) begin
            if (sh < 63) begin
               t   = div_odd(INVPI_Q62 >> sh, k);
               sum = k[0] ? sum - t : sum + t;
               sh  = sh + 2 * i;
            end
         end
      end
      return sum;
   endfunction

   function automatic angle_arr_type build_angles();
      angle_arr_type a;
      int n;
      for (n = 0; n < CORDIC_STEPS; n++) begin
         a[n] = half_turn_angle(n);
      end
      return a;
   endfunction

   localparam angle_arr_type ANGLE_TABLE = build_angles();

endpackage

`default_nettype wire

### rtl/periodic_atan_kernel_direct_sum.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  patk_pkg::req_type, one source-target pair
// rsp_      out        rsp_valid/rsp_stall  patk_pkg::rsp_type, one result per last source
// csr_      in         csr_we               csr_index selects register, csr_wdata value
//
// The front takes a request per cycle, stalled while register and queue are both full, into
// a one-stage multiply and classify register that feeds a two-entry queue. The back runs
// one pair at a time: an unskipped pair runs ROT, SCALE, VEC, TERM, MUL and ACC on the
// shared CORDIC iteration; skipped pairs stay in IDLE and a last source adds PROD and SEND.
// Reset is synchronous and clears the sum and all valid flags; the CSRs return to defaults.
// A stalled result holds in the output register and the back waits until it is taken.
`default_nettype none

module periodic_atan_kernel_direct_sum (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire patk_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output patk_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [patk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [31:0]                          csr_wdata
);
   import patk_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_full, q_empty, q_push, q_pop;
   pair_type q_in_data, q_out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INV_DOMAIN: cfg_in.inv_domain_length = csr_wdata;
            CSR_STRETCH:    cfg_in.stretch           = csr_wdata;
            CSR_WEIGHT_ADJ: cfg_in.weight_adjust     = csr_wdata;
            CSR_POLE_TOL:   cfg_in.pole_tolerance    = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_domain_length <= ONE_Q24;
         cfg_ff.stretch           <= ONE_Q24;
         cfg_ff.weight_adjust     <= ONE_Q24;
         cfg_ff.pole_tolerance    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   patk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   patk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out_data)
   );

   patk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/patk_queue.sv
`default_nettype none

module patk_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire patk_pkg::pair_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output patk_pkg::pair_type      pop_data
);
   import patk_pkg::*;

   pair_type                entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;

   assign full     = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/patk_front.sv
`default_nettype none

module patk_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire patk_pkg::cfg_type  cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire patk_pkg::req_type  req_data,
   input  wire logic               q_full,
   output logic                    q_push,
   output patk_pkg::pair_type      q_data
);
   import patk_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic [63:0]            s1_prod_ff;
   logic                   s1_neg_ff;
   logic signed [39:0]     s1_qw_ff;
   logic                   s1_last_ff;
   logic [INDEX_BITS-1:0]  s1_index_ff;

   logic signed [32:0]     diff;
   logic [32:0]            mag;
   logic [64:0]            mag_prod;
   logic signed [63:0]     qw_prod;
   logic                   accept;

   logic [39:0]            p;
   logic signed [41:0]     dz;
   logic signed [41:0]     d_hi, d_lo;
   logic [41:0]            abs_hi, abs_lo;
   logic signed [42:0]     wr;
   logic [23:0]            shifted;

   assign accept    = req_valid && !req_stall;
   assign req_stall = s1_valid_ff && q_full;
   assign q_push    = s1_valid_ff && !q_full;

   always_comb begin
      diff     = {req_data.tgt_pos[31], req_data.tgt_pos}
               - {req_data.src_pos[31], req_data.src_pos};
      mag      = diff[32] ? 33'(-diff) : 33'(diff);
      mag_prod = mag * cfg.inv_domain_length;
      qw_prod  = req_data.src_charge * req_data.src_weight;
      s1_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff  <= mag_prod[63:0];
         s1_neg_ff   <= diff[32];
         s1_qw_ff    <= qw_prod[63:24];
         s1_last_ff  <= req_data.last_source;
         s1_index_ff <= req_data.target_index;
      end
   end

   always_comb begin
      p      = s1_prod_ff[63:24];
      dz     = s1_neg_ff ? -$signed({2'b00, p}) : $signed({2'b00, p});
      d_hi   = dz - 42'sd8388608;
      d_lo   = dz + 42'sd8388608;
      abs_hi = d_hi[41] ? 42'(-d_hi) : 42'(d_hi);
      abs_lo = d_lo[41] ? 42'(-d_lo) : 42'(d_lo);
      wr     = 43'sd8388608 - {dz[41], dz};
      shifted = dz[23:0] + 24'h80_0000;

      q_data.index = s1_index_ff;
      q_data.last  = s1_last_ff;
      q_data.qw    = s1_qw_ff;
      q_data.skip  = (abs_hi <= {34'd0, cfg.pole_tolerance})
                  || (abs_lo <= {34'd0, cfg.pole_tolerance});
      q_data.phase = $signed({~shifted[23], shifted[22:0]});
      if (wr[42] && (wr[23:0] == 24'd0)) begin
         q_data.frac = ONE_Q24[24:0];
      end else begin
         q_data.frac = {1'b0, wr[23:0]};
      end
   end

endmodule

`default_nettype wire

### rtl/patk_back.sv
`default_nettype none

module patk_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire patk_pkg::cfg_type  cfg,
   input  wire logic               q_empty,
   input  wire patk_pkg::pair_type q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output patk_pkg::rsp_type       rsp_data
);
   import patk_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_ROT   = 9'b0_0000_0010,
      ST_SCALE = 9'b0_0000_0100,
      ST_VEC   = 9'b0_0000_1000,
      ST_TERM  = 9'b0_0001_0000,
      ST_MUL   = 9'b0_0010_0000,
      ST_ACC   = 9'b0_0100_0000,
      ST_PROD  = 9'b0_1000_0000,
      ST_SEND  = 9'b1_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   pair_type                ent_ff, ent_in;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [63:0]      z_ff, z_in;
   logic signed [27:0]      term_ff, term_in;
   logic signed [63:0]      c_ff, c_in;
   logic signed [63:0]      sum_ff, sum_in;
   logic [63:0]             hi_ff, hi_in;
   logic [39:0]             lo_ff, lo_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [XY_W-1:0]  xs, ys;
   logic signed [63:0]      ang;
   logic signed [65:0]      scale_prod;
   logic signed [67:0]      c_prod;
   logic signed [64:0]      sum_wide;
   logic [63:0]             m;
   logic [63:0]             lo_prod;
   logic [63:0]             hi_shift;
   logic [63:0]             res;
   logic                    out_free;
   logic                    last_step;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign last_step = (step_ff == STEP_BITS'(CORDIC_STEPS - 1));

   always_comb begin
      xs         = x_ff >>> step_ff;
      ys         = y_ff >>> step_ff;
      ang        = ANGLE_TABLE[step_ff];
      scale_prod = $signed(y_ff[32:0]) * $signed({1'b0, cfg.stretch});
      c_prod     = ent_ff.qw * term_ff;
      sum_wide   = {sum_ff[63], sum_ff} + {c_ff[63], c_ff};
      m          = sum_ff[63] ? 64'(-sum_ff) : 64'(sum_ff);
      lo_prod    = m[31:0] * cfg.weight_adjust;
      hi_shift   = {hi_ff[55:0], 8'd0};
      if (hi_ff > {8'd0, SUM_LIMIT[63:8]}) begin
         res = SUM_LIMIT;
      end else if (hi_shift > SUM_LIMIT - {24'd0, lo_ff}) begin
         res = SUM_LIMIT;
      end else begin
         res = hi_shift + {24'd0, lo_ff};
      end

      state_in     = state_ff;
      step_in      = step_ff;
      ent_in       = ent_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      term_in      = term_ff;
      c_in         = c_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               ent_in  = q_data;
               x_in    = XY_W'(48'sh0000_4000_0000);
               y_in    = '0;
               z_in    = {{2{q_data.phase[23]}}, q_data.phase, 38'd0};
               step_in = '0;
               if (!q_data.skip) begin
                  state_in = ST_ROT;
               end else if (q_data.last) begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_ROT: begin
            if (!z_ff[63]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            y_in     = {{(XY_W - 42){scale_prod[65]}}, scale_prod[65:24]};
            z_in     = '0;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            if (y_ff[XY_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            term_in  = {{2{z_ff[63]}}, z_ff[63:38]} + $signed({3'b000, ent_ff.frac})
                     - 28'sd8388608;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            c_in     = c_prod[63:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sum_wide[64] != sum_wide[63]) begin
               sum_in = sum_wide[64] ? {1'b1, 63'd0} : $signed(SUM_LIMIT);
            end else begin
               sum_in = sum_wide[63:0];
            end
            state_in = ent_ff.last ? ST_PROD : ST_IDLE;
         end
         ST_PROD: begin
            hi_in    = m[63:32] * cfg.weight_adjust;
            lo_in    = lo_prod[63:24];
            neg_in   = sum_ff[63];
            sum_in   = '0;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.result_target       = ent_ff.index;
               rsp_data_in.potential_increment = neg_ff ? -$signed(res) : $signed(res);
               state_in                        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      term_ff     <= term_in;
      c_ff        <= c_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
